// ===== src/assert_macros.svh =====
// assertion macros for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("%m: assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

// ===== src/ddde_pkg.sv =====
// shared types, constants and helpers of the digit display encoder
package ddde_pkg;

	localparam int unsigned DISPLAY_POSITIONS = 4;

	localparam logic [14:0] INT_LIMIT  = 15'd1000;
	localparam logic [14:0] SAT_LIMIT  = 15'd999;
	localparam logic [2:0]  MAX_WANT   = 3'(DISPLAY_POSITIONS);
	localparam logic [2:0]  POS_FIRST  = 3'(DISPLAY_POSITIONS);
	localparam logic [2:0]  POS_UNIT   = 3'd1;
	localparam logic [2:0]  POS_PRE    = 3'd2;
	localparam logic [3:0]  LAST_SUM   = 4'(DISPLAY_POSITIONS + 1);
	localparam logic [2:0]  K_WIDE     = 3'd4;
	localparam logic [2:0]  K_NARROW   = 3'd2;
	localparam logic [2:0]  K_THOUSAND = 3'd3;
	localparam logic [2:0]  K_UNITS    = 3'd0;
	localparam logic [3:0]  UNIT_SMALL = 4'd1;
	localparam logic [3:0]  UNIT_LARGE = 4'd2;

	typedef enum logic [1:0] {
		SRC_INT,
		SRC_FRAC,
		SRC_UNIT
	} src_t;

	typedef struct packed {
		logic       load;
		logic       emit;
		logic       extract;
		logic       frac_step;
		src_t       sel;
		logic [2:0] pos;
		logic       point;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic       action;
		logic       big;
		logic [2:0] want;
		logic [3:0] int_digit;
		logic [2:0] k;
	} status_t;

	function automatic logic [16:0] pow10(input logic [2:0] k);
		logic [16:0] p;
		case (k)
			3'd0: p = 17'd1;
			3'd1: p = 17'd10;
			3'd2: p = 17'd100;
			3'd3: p = 17'd1000;
			3'd4: p = 17'd10000;
			default: p = 17'd1;
		endcase
		return p;
	endfunction

endpackage

// ===== src/ddde_dp.sv =====
// datapath: operand registers, digit extraction and output payload registers
module ddde_dp import ddde_pkg::*; (
	input  logic        clk,
	input  logic        action,
	input  logic [14:0] whole,
	input  logic [15:0] fraction,
	input  logic [2:0]  digits,
	input  cmd_t        cmd,
	output status_t     st,
	output logic [3:0]  digit_value,
	output logic [2:0]  position,
	output logic        point,
	output logic        last
);

	logic [14:0] r_q;
	logic [2:0]  k_q;
	logic [15:0] frac_q;
	logic        action_q;
	logic        big_q;
	logic [2:0]  want_q;
	logic [3:0]  digit_q;
	logic [2:0]  pos_q;
	logic        point_q;
	logic        last_q;

	logic [16:0] pw;
	logic [16:0] thr [0:9];
	logic [3:0]  dig;
	logic [14:0] rem;
	logic [19:0] ft;

	// digit of r_q at weight 10^k by parallel compare against its multiples
	always_comb begin
		pw = pow10(k_q);
		for (int j = 0; j < 10; j++) begin
			thr[j] = 17'(pw * 17'(j));
		end
		dig = 4'd0;
		for (int j = 1; j < 10; j++) begin
			if ({2'b00, r_q} >= thr[j]) begin
				dig = 4'(j);
			end
		end
		rem = 15'({2'b00, r_q} - thr[dig]);
		ft  = ({4'd0, frac_q} << 3) + ({4'd0, frac_q} << 1);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			big_q    <= (whole >= INT_LIMIT);
			frac_q   <= fraction;
			want_q   <= (digits > MAX_WANT) ? MAX_WANT : digits;
			if (action) begin
				r_q <= (whole > SAT_LIMIT) ? SAT_LIMIT : whole;
				k_q <= K_NARROW;
			end else begin
				r_q <= whole;
				k_q <= (whole >= INT_LIMIT) ? K_WIDE : K_NARROW;
			end
		end else begin
			if (cmd.extract) begin
				r_q <= rem;
				k_q <= k_q - 3'd1;
			end
			if (cmd.frac_step) begin
				frac_q <= ft[15:0];
			end
		end
		if (cmd.emit) begin
			case (cmd.sel)
				SRC_INT:  digit_q <= dig;
				SRC_FRAC: digit_q <= ft[19:16];
				SRC_UNIT: digit_q <= big_q ? UNIT_LARGE : UNIT_SMALL;
				default:  digit_q <= dig;
			endcase
			pos_q   <= cmd.pos;
			point_q <= cmd.point;
			last_q  <= cmd.last;
		end
	end

	assign st.action    = action_q;
	assign st.big       = big_q;
	assign st.want      = want_q;
	assign st.int_digit = dig;
	assign st.k         = k_q;

	assign digit_value = digit_q;
	assign position    = pos_q;
	assign point       = point_q;
	assign last        = last_q;

endmodule

// ===== src/ddde_ctrl.sv =====
// controller: sequences the digit codes of one request and owns both handshakes
module ddde_ctrl import ddde_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  status_t st,
	output cmd_t    cmd
);

	typedef enum logic [1:0] {
		IDLE,
		INT_DIG,
		FRAC_DIG,
		UNIT_DIG
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] pos_q, pos_d;
	logic       started_q, started_d;
	logic       out_valid_q, out_valid_d;

	logic       slot;
	logic       show;
	logic       ends;
	logic [3:0] pos_sum;

	always_comb begin
		slot    = !out_valid_q || !out_stall;
		pos_sum = {1'b0, pos_q} + {1'b0, st.want};
		// no fraction digit left once the next position would overflow the request
		ends    = (pos_sum <= LAST_SUM);
		// leading zeros are dropped except in integer mode below a thousand and for the units digit
		show    = (!st.action && !st.big) || started_q || (st.int_digit != 4'd0)
			|| (st.k == K_UNITS);

		cmd       = '0;
		cmd.sel   = SRC_INT;
		cmd.pos   = pos_q;
		state_d   = state_q;
		pos_d     = pos_q;
		started_d = started_q;

		case (state_q)
			IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_d   = INT_DIG;
					pos_d     = POS_FIRST;
					started_d = 1'b0;
				end
			end
			INT_DIG: begin
				if (!show) begin
					cmd.extract = 1'b1;
				end else if (slot) begin
					cmd.extract = 1'b1;
					cmd.emit    = 1'b1;
					cmd.point   = st.action ? (st.k == K_UNITS)
						: (st.big && (st.k == K_THOUSAND));
					cmd.last    = st.action && (st.k == K_UNITS) && ends;
					pos_d       = pos_q - 3'd1;
					started_d   = 1'b1;
					if (!st.action) begin
						if (pos_q == POS_PRE) begin
							state_d = UNIT_DIG;
						end
					end else if (st.k == K_UNITS) begin
						state_d = ends ? IDLE : FRAC_DIG;
					end
				end
			end
			FRAC_DIG: begin
				if (slot) begin
					cmd.emit      = 1'b1;
					cmd.frac_step = 1'b1;
					cmd.sel       = SRC_FRAC;
					cmd.last      = ends;
					pos_d         = pos_q - 3'd1;
					if (ends) begin
						state_d = IDLE;
					end
				end
			end
			UNIT_DIG: begin
				if (slot) begin
					cmd.emit = 1'b1;
					cmd.sel  = SRC_UNIT;
					cmd.pos  = POS_UNIT;
					cmd.last = 1'b1;
					state_d  = IDLE;
				end
			end
			default: begin
				state_d = IDLE;
			end
		endcase

		if (cmd.emit) begin
			out_valid_d = 1'b1;
		end else if (!out_stall) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			pos_q       <= POS_FIRST;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			pos_q       <= pos_d;
			started_q   <= started_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign in_stall  = (state_q != IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== src/decimal_digit_display_encoder.sv =====
// top level of the decimal digit display encoder
// Usage:
// A request (action, whole, fraction, digits) is taken on the input channel
// when in_valid is high and in_stall is low. It becomes a run of one to four
// digit codes on the output channel, positions 4 down to 1, the final one
// marked by last. A code moves when out_valid is high and out_stall is low.
// Integer mode sends three digits and a unit code; fixed-point mode sends
// the integer part without leading zeros, point on its units digit, then
// fraction digits up to the requested number of positions.
// The request is first loaded into the operand registers; the first code
// then passes the output register, held back by each dropped leading zero.
// The controller steps one digit per cycle, while the receiver does not
// stall, through a single output register; a request occupies the block
// from its load through each of its codes and each dropped zero.
// in_stall stays high until the last code of the run is in the output
// register; the next request can then be taken while that code still waits.
// A stalled receiver freezes the run with the pending code held in place.
// Reset clears the controller and the output valid; the block starts idle.
module decimal_digit_display_encoder import ddde_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [14:0] whole,
	input  logic [15:0] fraction,
	input  logic [2:0]  digits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  digit_value,
	output logic [2:0]  position,
	output logic        point,
	output logic        last
);

	cmd_t    cmd;
	status_t st;

	ddde_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	ddde_dp u_dp (
		.clk         (clk),
		.action      (action),
		.whole       (whole),
		.fraction    (fraction),
		.digits      (digits),
		.cmd         (cmd),
		.st          (st),
		.digit_value (digit_value),
		.position    (position),
		.point       (point),
		.last        (last)
	);

endmodule

// ===== src/ddde_chk.sv =====
// port-level checker of the digit display encoder and its bind
`include "assert_macros.svh"

module ddde_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        action,
	input logic [14:0] whole,
	input logic [15:0] fraction,
	input logic [2:0]  digits,
	input logic        out_valid,
	input logic        out_stall,
	input logic [3:0]  digit_value,
	input logic [2:0]  position,
	input logic        point,
	input logic        last
);

	// a digit code never names a position outside the display
	`ASSERT_HOLDS(a_pos_range, clk, arst_n, !out_valid || (position >= 3'd1 && position <= 3'd4))
	// only decimal digits or unit codes reach the display
	`ASSERT_HOLDS(a_digit_range, clk, arst_n, !out_valid || (digit_value <= 4'd9))
	// a taken request closes the input behind it
	`ASSERT_NEXT(a_busy_after_req, clk, arst_n, in_valid && !in_stall, in_stall)
	// a stalled code stays in place
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(digit_value) && $stable(position) && $stable(last))

endmodule

bind decimal_digit_display_encoder ddde_chk u_ddde_chk (.*);
